@@ design/m3inv_pkg.sv @@
`timescale 1ns / 1ps
package m3inv_pkg;
  // Width of one inverse element, signed Q16.16
  localparam int INV_BITS = 32;
  // Fraction bits of an inverse element
  localparam int INV_FRAC = 16;
  // Number of matrix elements
  localparam int NUM_ELEM = 9;
endpackage

@@ design/matrix3x3_inverse_determinant_core.sv @@
`timescale 1ns / 1ps
// Channel  | Ports                              | Handshake
// ---------+------------------------------------+-------------------------------
// input    | in_a11 .. in_a33                   | word taken when start && !busy
// result   | out_inv11..33, out_determinant,    | out_valid high for one cycle
//          | out_singular                       |
// One matrix word is taken every cycle; busy stays low.
// Five arithmetic stages (products, cofactors, determinant terms, determinant
// sum, overflow check), 32 quotient stages of the nine restoring dividers (one
// quotient bit per stage) and one saturation stage.
// Reset clears the valid bits only; data registers run free.
// The result is shown for one cycle and cannot be held off.
module matrix3x3_inverse_determinant_core #(
  parameter int ELEMENT_BITS  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic signed [ELEMENT_BITS-1:0] in_a11,
  input  logic signed [ELEMENT_BITS-1:0] in_a12,
  input  logic signed [ELEMENT_BITS-1:0] in_a13,
  input  logic signed [ELEMENT_BITS-1:0] in_a21,
  input  logic signed [ELEMENT_BITS-1:0] in_a22,
  input  logic signed [ELEMENT_BITS-1:0] in_a23,
  input  logic signed [ELEMENT_BITS-1:0] in_a31,
  input  logic signed [ELEMENT_BITS-1:0] in_a32,
  input  logic signed [ELEMENT_BITS-1:0] in_a33,
  output logic out_valid,
  output logic signed [m3inv_pkg::INV_BITS-1:0] out_inv11,
  output logic signed [m3inv_pkg::INV_BITS-1:0] out_inv12,
  output logic signed [m3inv_pkg::INV_BITS-1:0] out_inv13,
  output logic signed [m3inv_pkg::INV_BITS-1:0] out_inv21,
  output logic signed [m3inv_pkg::INV_BITS-1:0] out_inv22,
  output logic signed [m3inv_pkg::INV_BITS-1:0] out_inv23,
  output logic signed [m3inv_pkg::INV_BITS-1:0] out_inv31,
  output logic signed [m3inv_pkg::INV_BITS-1:0] out_inv32,
  output logic signed [m3inv_pkg::INV_BITS-1:0] out_inv33,
  output logic signed [3*ELEMENT_BITS+2:0] out_determinant,
  output logic out_singular
);

  localparam int E   = ELEMENT_BITS;
  localparam int PW  = 2 * E;
  localparam int CW  = 2 * E + 1;
  localparam int TW  = E + CW;
  localparam int DW  = 3 * E + 3;
  localparam int IB  = m3inv_pkg::INV_BITS;
  localparam int NE  = m3inv_pkg::NUM_ELEM;
  localparam int SH  = FRACTION_BITS + m3inv_pkg::INV_FRAC;
  localparam int NW  = CW + SH;
  localparam int WW  = ((NW > DW + IB) ? NW : DW + IB) + 1;

  logic signed [E-1:0] a_in [0:NE-1];

  assign a_in[0] = in_a11;
  assign a_in[1] = in_a12;
  assign a_in[2] = in_a13;
  assign a_in[3] = in_a21;
  assign a_in[4] = in_a22;
  assign a_in[5] = in_a23;
  assign a_in[6] = in_a31;
  assign a_in[7] = in_a32;
  assign a_in[8] = in_a33;

  assign busy = 1'b0;

  // stage 1: cofactor products
  logic              v1_r;
  logic signed [PW-1:0] p1_r [0:NE-1];
  logic signed [PW-1:0] p2_r [0:NE-1];
  logic signed [E-1:0]  row1_1_r [0:2];

  // stage 2: cofactors
  logic              v2_r;
  logic signed [CW-1:0] cof2_r [0:NE-1];
  logic signed [E-1:0]  row1_2_r [0:2];

  // stage 3: determinant terms
  logic              v3_r;
  logic signed [TW-1:0] term3_r [0:2];
  logic signed [CW-1:0] cof3_r [0:NE-1];

  // stage 4: determinant and magnitudes
  logic              v4_r;
  logic signed [DW-1:0] det4_r;
  logic [CW-1:0]        cmag4_r [0:NE-1];
  logic [NE-1:0]        cneg4_r;

  // divider pipe: index 0 is the overflow-check stage
  logic              dv_r    [0:IB];
  logic [WW-1:0]     rem_r   [0:IB][0:NE-1];
  logic [IB-1:0]     quo_r   [0:IB][0:NE-1];
  logic [NE-1:0]     neg_r   [0:IB];
  logic [NE-1:0]     ovf_r   [0:IB];
  logic [DW-1:0]     dmag_r  [0:IB];
  logic signed [DW-1:0] det_r [0:IB];
  logic              sing_r  [0:IB];

  genvar gr, gc, gs;

  // form the two products of each cyclic 2x2 minor
  generate
    for (gr = 0; gr < 3; gr++) begin : g_row
      for (gc = 0; gc < 3; gc++) begin : g_col
        localparam int R1 = (gr + 1) % 3;
        localparam int R2 = (gr + 2) % 3;
        localparam int C1 = (gc + 1) % 3;
        localparam int C2 = (gc + 2) % 3;
        always_ff @(posedge clk) begin
          p1_r[gr*3+gc] <= PW'(a_in[R1*3+C1] * a_in[R2*3+C2]);
          p2_r[gr*3+gc] <= PW'(a_in[R2*3+C1] * a_in[R1*3+C2]);
        end
      end
    end
  endgenerate

  // advance valid bits of the arithmetic stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // cofactors, determinant terms, determinant sum, cofactor signs and magnitudes
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      row1_1_r[j] <= a_in[j];
      row1_2_r[j] <= row1_1_r[j];
      term3_r[j]  <= TW'(row1_2_r[j] * cof2_r[j]);
    end
    for (int i = 0; i < NE; i++) begin
      cof2_r[i]  <= CW'(p1_r[i]) - CW'(p2_r[i]);
      cof3_r[i]  <= cof2_r[i];
      cneg4_r[i] <= cof3_r[i][CW-1];
      cmag4_r[i] <= cof3_r[i][CW-1] ? CW'(-cof3_r[i]) : CW'(cof3_r[i]);
    end
    det4_r <= DW'(term3_r[0]) + DW'(term3_r[1]) + DW'(term3_r[2]);
  end

  // overflow check: quotient would not fit in the quotient register
  always_ff @(posedge clk) begin
    logic [DW-1:0] dm;
    logic [WW-1:0] num;
    dm = det4_r[DW-1] ? DW'(-det4_r) : DW'(det4_r);
    for (int i = 0; i < NE; i++) begin
      // inverse element (r,c) divides cofactor (c,r)
      num = WW'(cmag4_r[(i%3)*3 + i/3]) << SH;
      rem_r[0][i] <= num;
      quo_r[0][i] <= '0;
      neg_r[0][i] <= cneg4_r[(i%3)*3 + i/3] ^ det4_r[DW-1];
      ovf_r[0][i] <= (num >= (WW'(dm) << IB));
    end
    dmag_r[0] <= dm;
    det_r[0]  <= det4_r;
    sing_r[0] <= (det4_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= v4_r;
    end
  end

  // one quotient bit per stage, restoring
  generate
    for (gs = 0; gs < IB; gs++) begin : g_div
      localparam int K = IB - 1 - gs;
      always_ff @(posedge clk) begin
        logic [WW-1:0] dsh;
        dsh = WW'(dmag_r[gs]) << K;
        for (int i = 0; i < NE; i++) begin
          if (rem_r[gs][i] >= dsh) begin
            rem_r[gs+1][i] <= rem_r[gs][i] - dsh;
            quo_r[gs+1][i] <= quo_r[gs][i] | (IB'(1) << K);
          end else begin
            rem_r[gs+1][i] <= rem_r[gs][i];
            quo_r[gs+1][i] <= quo_r[gs][i];
          end
        end
        neg_r[gs+1]  <= neg_r[gs];
        ovf_r[gs+1]  <= ovf_r[gs];
        dmag_r[gs+1] <= dmag_r[gs];
        det_r[gs+1]  <= det_r[gs];
        sing_r[gs+1] <= sing_r[gs];
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[gs+1] <= 1'b0;
        end else begin
          dv_r[gs+1] <= dv_r[gs];
        end
      end
    end
  endgenerate

  // saturate, apply sign and zero a singular result
  logic [IB-1:0] inv_r [0:NE-1];
  logic signed [DW-1:0] det_out_r;
  logic sing_out_r;
  logic vout_r;

  always_ff @(posedge clk) begin
    logic [IB-1:0] q;
    for (int i = 0; i < NE; i++) begin
      q = quo_r[IB][i];
      if (sing_r[IB]) begin
        inv_r[i] <= '0;
      end else if (neg_r[IB][i]) begin
        if (ovf_r[IB][i] || q > {1'b1, {(IB-1){1'b0}}}) begin
          inv_r[i] <= {1'b1, {(IB-1){1'b0}}};
        end else begin
          inv_r[i] <= IB'(-q);
        end
      end else begin
        if (ovf_r[IB][i] || q[IB-1]) begin
          inv_r[i] <= {1'b0, {(IB-1){1'b1}}};
        end else begin
          inv_r[i] <= q;
        end
      end
    end
    det_out_r  <= det_r[IB];
    sing_out_r <= sing_r[IB];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else begin
      vout_r <= dv_r[IB];
    end
  end

  assign out_valid       = vout_r;
  assign out_inv11       = inv_r[0];
  assign out_inv12       = inv_r[1];
  assign out_inv13       = inv_r[2];
  assign out_inv21       = inv_r[3];
  assign out_inv22       = inv_r[4];
  assign out_inv23       = inv_r[5];
  assign out_inv31       = inv_r[6];
  assign out_inv32       = inv_r[7];
  assign out_inv33       = inv_r[8];
  assign out_determinant = det_out_r;
  assign out_singular    = sing_out_r;

endmodule

@@ design/m3inv_checker.sv @@
`timescale 1ns / 1ps
module m3inv_checker #(
  parameter int DET_W = 51
) (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic [m3inv_pkg::INV_BITS-1:0] out_inv11,
  input logic [m3inv_pkg::INV_BITS-1:0] out_inv22,
  input logic [DET_W-1:0] out_determinant,
  input logic out_singular
);

  // the core takes a word every cycle
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // singular flag agrees with the determinant
  a_sing_det: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_singular == (out_determinant == '0)))
    else $error("singular flag and determinant disagree");

  // singular result carries a zero inverse (inv11 and inv22 are checked)
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (out_inv11 == '0 && out_inv22 == '0))
    else $error("singular result with nonzero inverse");

  // nothing strobes out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind matrix3x3_inverse_determinant_core m3inv_checker #(
  .DET_W(3 * ELEMENT_BITS + 3)
) u_m3inv_checker (
  .clk(clk),
  .rst_n(rst_n),
  .busy(busy),
  .out_valid(out_valid),
  .out_inv11(out_inv11),
  .out_inv22(out_inv22),
  .out_determinant(out_determinant),
  .out_singular(out_singular)
);

@@ tb/sv/matrix3x3_inverse_determinant_core_tb.sv @@
`timescale 1ns / 1ps
module matrix3x3_inverse_determinant_core_tb;

  localparam int NUM_ELEM = m3inv_pkg::NUM_ELEM;
  localparam int INV_BITS = m3inv_pkg::INV_BITS;
  localparam int INV_FRAC = m3inv_pkg::INV_FRAC;
  localparam int EB = 16;
  localparam int FB = 8;
  localparam int DET_W = 3*EB+3;
  localparam int LATENCY = 38;
  localparam int WATCHDOG = 2000;
  localparam int RANDOM_WORDS = 700;

  // expected inverse, determinant and singular flag of one matrix
  typedef struct packed {
    logic [NUM_ELEM-1:0][INV_BITS-1:0] inv;
    logic [DET_W-1:0] det;
    logic sing;
  } inverse_t;

  // directed row: matrix, whether a typed-in answer exists, the answer
  typedef struct {
    logic [NUM_ELEM-1:0][EB-1:0] m;
    bit known;
    inverse_t ans;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [NUM_ELEM-1:0][EB-1:0] mat_in = '0;
  logic out_valid;
  logic signed [INV_BITS-1:0] inv_out [NUM_ELEM];
  logic signed [DET_W-1:0] out_determinant;
  logic out_singular;

  inverse_t expected_inverses[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit quiet_stretch = 1'b0;

  always #5 clk = ~clk;

  matrix3x3_inverse_determinant_core #(.ELEMENT_BITS(EB), .FRACTION_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a11(mat_in[0]), .in_a12(mat_in[1]), .in_a13(mat_in[2]),
    .in_a21(mat_in[3]), .in_a22(mat_in[4]), .in_a23(mat_in[5]),
    .in_a31(mat_in[6]), .in_a32(mat_in[7]), .in_a33(mat_in[8]),
    .out_valid(out_valid),
    .out_inv11(inv_out[0]), .out_inv12(inv_out[1]), .out_inv13(inv_out[2]),
    .out_inv21(inv_out[3]), .out_inv22(inv_out[4]), .out_inv23(inv_out[5]),
    .out_inv31(inv_out[6]), .out_inv32(inv_out[7]), .out_inv33(inv_out[8]),
    .out_determinant(out_determinant), .out_singular(out_singular)
  );

  // saturating Q16.16 quotient of cofactor over determinant, truncated toward zero
  function automatic logic [INV_BITS-1:0] scaled_quotient(longint cof, longint det);
    logic [127:0] n, d, q;
    bit neg;
    n = cof < 0 ? -cof : cof;
    d = det < 0 ? -det : det;
    q = (n << (FB + INV_FRAC)) / d;
    neg = (cof < 0) != (det < 0);
    if (neg) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return -q[INV_BITS-1:0];
    end
    if (q > 128'h7fff_ffff) q = 128'h7fff_ffff;
    return q[INV_BITS-1:0];
  endfunction

  // inverse by the adjugate, determinant by Sarrus
  function automatic inverse_t invert_matrix(logic [NUM_ELEM-1:0][EB-1:0] m);
    longint a [3][3];
    longint cof [3][3];
    longint det;
    inverse_t res;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) a[r][c] = longint'($signed(m[r*3+c]));
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        cof[r][c] = a[(r+1)%3][(c+1)%3] * a[(r+2)%3][(c+2)%3]
                  - a[(r+2)%3][(c+1)%3] * a[(r+1)%3][(c+2)%3];
    det = 0;
    for (int i = 0; i < 3; i++) det += a[i][0] * a[(i+1)%3][1] * a[(i+2)%3][2];
    for (int i = 0; i < 3; i++) det -= a[i][0] * a[(i+2)%3][1] * a[(i+1)%3][2];
    res = '0;
    if (det == 0) begin
      res.sing = 1'b1;
      return res;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) res.inv[r*3+c] = scaled_quotient(cof[c][r], det);
    res.det = det[DET_W-1:0];
    return res;
  endfunction

  function automatic logic [NUM_ELEM-1:0][EB-1:0] diag_matrix(logic [EB-1:0] v);
    logic [NUM_ELEM-1:0][EB-1:0] m;
    m = '0;
    m[0] = v; m[4] = v; m[8] = v;
    return m;
  endfunction

  // random element: mostly full range, some near zero or at the extremes
  function automatic logic [EB-1:0] random_element();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3: return EB'($signed($urandom_range(0, 1024)) - 512);
      default: return EB'($urandom);
    endcase
  endfunction

  // send one matrix word; hold start until accepted
  task automatic send_word(logic [NUM_ELEM-1:0][EB-1:0] m);
    if (!quiet_stretch) begin
      while ($urandom_range(0, 99) < 12) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start <= 1'b1;
    mat_in <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_inverses.push_back(invert_matrix(m));
    @(negedge clk);
  endtask

  // check each result word against the oldest expectation
  always @(posedge clk) begin
    inverse_t got, want;
    if (rst_n && out_valid) begin
      idle_cycles <= 0;
      for (int i = 0; i < NUM_ELEM; i++) got.inv[i] = inv_out[i];
      got.det = out_determinant;
      got.sing = out_singular;
      if (expected_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %h", got);
      end else begin
        want = expected_inverses.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected inv=%h det=%h sing=%b, got inv=%h det=%h sing=%b",
                     want.inv, want.det, want.sing, got.inv, got.det, got.sing);
        end
      end
    end else if (start && !busy && rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("matrix3x3_inverse_determinant_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    inverse_t zero_ans;
    logic [NUM_ELEM-1:0][EB-1:0] m;
    zero_ans = '0;
    zero_ans.sing = 1'b1;

    // singular: all zeros, all ones, rank one
    row.known = 1'b1; row.ans = zero_ans;
    row.m = '0; rows.push_back(row);
    row.m = {NUM_ELEM{16'h0100}}; rows.push_back(row);
    row.m = {NUM_ELEM{16'h8000}}; rows.push_back(row);
    row.m = {NUM_ELEM{16'h7fff}}; rows.push_back(row);
    // identity: inverse is identity in Q16.16, det 1.0 in Q27.24
    row.m = diag_matrix(16'h0100);
    row.ans = '0;
    row.ans.inv[0] = 32'h0001_0000; row.ans.inv[4] = 32'h0001_0000;
    row.ans.inv[8] = 32'h0001_0000;
    row.ans.det = 51'h100_0000;
    rows.push_back(row);
    // predictor-checked rows: extremes, overflow, negatives, truncation
    row.known = 1'b0;
    row.m = diag_matrix(16'h0001); rows.push_back(row);
    row.m = diag_matrix(16'hffff); rows.push_back(row);
    row.m = diag_matrix(16'h8000); rows.push_back(row);
    row.m = diag_matrix(16'h7fff); rows.push_back(row);
    row.m = diag_matrix(16'h0300); rows.push_back(row);
    row.m = diag_matrix(16'hfd00); rows.push_back(row);
    row.m = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
             16'h7fff, 16'h8000, 16'h8001};
    rows.push_back(row);
    row.m = {16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h0000,
             16'h0000, 16'h0000, 16'h8000};
    rows.push_back(row);
    row.m = {16'h0200, 16'h0100, 16'h0000, 16'h0100, 16'h0300, 16'h0100,
             16'h0000, 16'h0100, 16'h0400};
    rows.push_back(row);
    row.m = {16'hff00, 16'h0700, 16'h0300, 16'h0500, 16'hfe00, 16'h0100,
             16'h0200, 16'h0100, 16'hfb00};
    rows.push_back(row);
    row.m = {16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'h1234,
             16'hfedc, 16'h8001, 16'h7ffe};
    rows.push_back(row);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      send_word(rows[i].m);
      if (rows[i].known) expected_inverses[$] = rows[i].ans;
    end

    // hold off until the pipeline drains once
    start <= 1'b0;
    while (expected_inverses.size() != 0) @(negedge clk);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quiet_stretch = (n >= 200 && n < 300);
      for (int i = 0; i < NUM_ELEM; i++) m[i] = random_element();
      // make some singular: copy or negate a row
      if ($urandom_range(0, 9) == 0) begin
        m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
      end else if ($urandom_range(0, 19) == 0) begin
        m[3] = -m[0]; m[4] = -m[1]; m[5] = -m[2];
      end
      send_word(m);
    end
    start <= 1'b0;

    while (expected_inverses.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (mismatches == 0) begin
      $display("matrix3x3_inverse_determinant_core_tb OK");
    end else begin
      $display("matrix3x3_inverse_determinant_core_tb NOT OK");
    end
    $finish;
  end
endmodule

@@ files.f @@
design/m3inv_pkg.sv
design/matrix3x3_inverse_determinant_core.sv
design/m3inv_checker.sv
tb/sv/matrix3x3_inverse_determinant_core_tb.sv
